FILE: rtl/pia_pkg.sv
package pia_pkg;

    localparam int INDEX_WIDTH  = 16;
    localparam int OFFSET_WIDTH = 24;
    localparam int RESULT_WIDTH = 25;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = OFFSET_WIDTH;

    // primitive mode codes, code 7 behaves as points
    localparam logic [2:0] MODE_LINES      = 3'd0;
    localparam logic [2:0] MODE_LINE_STRIP = 3'd1;
    localparam logic [2:0] MODE_TRIANGLES  = 3'd2;
    localparam logic [2:0] MODE_TRI_STRIP  = 3'd3;
    localparam logic [2:0] MODE_FAN        = 3'd4;
    localparam logic [2:0] MODE_QUADS      = 3'd5;
    localparam logic [2:0] MODE_POINTS     = 3'd6;

    // result kinds
    localparam logic [1:0] KIND_LINE  = 2'd0;
    localparam logic [1:0] KIND_FACE  = 2'd1;
    localparam logic [1:0] KIND_POINT = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PRIMITIVE_MODE = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_USE_SECOND_UV  = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_VERTEX_OFFSET  = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_NORMAL_OFFSET  = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TEX_OFFSET     = 3'd4;

    typedef logic [INDEX_WIDTH-1:0]  t_index;
    typedef logic [OFFSET_WIDTH-1:0] t_offset;
    typedef logic [RESULT_WIDTH-1:0] t_result_index;

    typedef struct packed {
        logic   list_start;
        t_index position_index;
        t_index normal_index;
        t_index uv_index_first;
        t_index uv_index_second;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]    prim_kind;
        logic          run_last;
        t_result_index a_position;
        t_result_index a_texcoord;
        t_result_index a_normal;
        t_result_index b_position;
        t_result_index b_texcoord;
        t_result_index b_normal;
        t_result_index c_position;
        t_result_index c_texcoord;
        t_result_index c_normal;
    } t_out_beat;

    // held vertex: texture index already chosen on arrival
    typedef struct packed {
        t_index pos;
        t_index nrm;
        t_index tex;
    } t_vertex;

    typedef struct packed {
        t_offset vtx;
        t_offset nrm;
        t_offset tex;
    } t_offsets;

    function automatic t_result_index f_add(input t_index idx, input t_offset off);
        f_add = t_result_index'(idx) + t_result_index'(off);
    endfunction

    function automatic t_out_beat f_line(input t_vertex a, input t_vertex b,
                                         input t_offsets off);
        t_out_beat r;
        r            = '0;
        r.prim_kind  = KIND_LINE;
        r.a_position = f_add(a.pos, off.vtx);
        r.a_texcoord = f_add(a.tex, off.tex);
        r.b_position = f_add(b.pos, off.vtx);
        r.b_texcoord = f_add(b.tex, off.tex);
        f_line = r;
    endfunction

    function automatic t_out_beat f_face(input t_vertex a, input t_vertex b,
                                         input t_vertex c, input t_offsets off);
        t_out_beat r;
        r            = '0;
        r.prim_kind  = KIND_FACE;
        r.a_position = f_add(a.pos, off.vtx);
        r.a_texcoord = f_add(a.tex, off.tex);
        r.a_normal   = f_add(a.nrm, off.nrm);
        r.b_position = f_add(b.pos, off.vtx);
        r.b_texcoord = f_add(b.tex, off.tex);
        r.b_normal   = f_add(b.nrm, off.nrm);
        r.c_position = f_add(c.pos, off.vtx);
        r.c_texcoord = f_add(c.tex, off.tex);
        r.c_normal   = f_add(c.nrm, off.nrm);
        f_face = r;
    endfunction

    function automatic t_out_beat f_point(input t_vertex a, input t_offsets off);
        t_out_beat r;
        r            = '0;
        r.prim_kind  = KIND_POINT;
        r.a_position = f_add(a.pos, off.vtx);
        r.b_position = r.a_position;
        r.c_position = r.a_position;
        f_point = r;
    endfunction

endpackage

FILE: rtl/primitive_index_assembler.sv
// Primitive assembler: turns a stream of vertex beats into line, face or
// point beats with offset-added indices.
// Input channel (i_in_valid / o_in_ready, i_in_beat): one vertex per beat,
// list_start opens a new primitive list.
// Output channel (o_out_valid / i_out_ready, o_out_beat): zero, one or two
// result beats per vertex, run_last marks the last one of each vertex.
// Config port (i_cfg_we, i_cfg_index, i_cfg_data): write-only registers, to be
// written by the user only while the block is idle; the block does not enforce it.
// A result is registered in the result queue when its vertex is accepted.
// Throughput: one vertex per cycle while the input is not held off; a completed
// quad puts two results into the three-entry result queue and the input pauses
// while the queue drains one beat per cycle when the receiver is ready.
// Reset: mode triangles, offsets zero, held vertices and list position
// cleared, result queue empty.
// When the receiver stalls the queue fills; the input is held off once two
// or more results wait.
module primitive_index_assembler (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  pia_pkg::t_in_beat                    i_in_beat,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output pia_pkg::t_out_beat                   o_out_beat,
    input  logic                                 i_cfg_we,
    input  logic [pia_pkg::CFG_INDEX_WIDTH-1:0]  i_cfg_index,
    input  logic [pia_pkg::CFG_DATA_WIDTH-1:0]   i_cfg_data
);

    localparam int QUEUE_DEPTH = 3;

    // configuration
    logic [2:0]       r_mode;
    logic             r_use_uv2;
    pia_pkg::t_offsets r_offsets;

    // list state
    pia_pkg::t_vertex r_held [3];
    pia_pkg::t_vertex r_anchor;
    pia_pkg::t_index  r_list_pos;
    logic [1:0]       r_phase3;

    // result queue
    pia_pkg::t_out_beat r_queue [QUEUE_DEPTH];
    logic [1:0]         r_wr_ptr;
    logic [1:0]         r_rd_ptr;
    logic [1:0]         r_count;

    pia_pkg::t_vertex   cur;
    pia_pkg::t_index    lpos;
    logic [1:0]         phase3;
    pia_pkg::t_out_beat res0;
    pia_pkg::t_out_beat res1;
    logic [1:0]         res_cnt;
    logic               in_fire;
    logic               out_fire;
    logic [1:0]         push_cnt;
    pia_pkg::t_index    n_list_pos;
    logic [1:0]         n_phase3;
    logic [1:0]         n_count;

    function automatic logic [1:0] f_ptr_inc(input logic [1:0] p);
        f_ptr_inc = (p == 2'(QUEUE_DEPTH - 1)) ? 2'd0 : p + 2'd1;
    endfunction

    assign o_in_ready  = (r_count < 2'd2);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = (r_count != 2'd0);
    assign out_fire    = o_out_valid && i_out_ready;
    assign o_out_beat  = r_queue[r_rd_ptr];

    // current vertex and its place in the list
    always_comb begin
        cur.pos = i_in_beat.position_index;
        cur.nrm = i_in_beat.normal_index;
        cur.tex = r_use_uv2 ? i_in_beat.uv_index_second : i_in_beat.uv_index_first;
        lpos    = i_in_beat.list_start ? '0 : r_list_pos;
        phase3  = i_in_beat.list_start ? 2'd0 : r_phase3;
        n_list_pos = (lpos == '1) ? pia_pkg::t_index'(4)
                                  : lpos + pia_pkg::t_index'(1);
        n_phase3   = (phase3 == 2'd2) ? 2'd0 : phase3 + 2'd1;
    end

    // primitive selection per mode
    always_comb begin
        res0    = '0;
        res1    = '0;
        res_cnt = 2'd0;
        unique case (r_mode)
            pia_pkg::MODE_LINES: begin
                if (lpos[0]) begin
                    res0    = pia_pkg::f_line(r_held[0], cur, r_offsets);
                    res_cnt = 2'd1;
                end
            end
            pia_pkg::MODE_LINE_STRIP: begin
                if (lpos != '0) begin
                    res0    = pia_pkg::f_line(r_held[0], cur, r_offsets);
                    res_cnt = 2'd1;
                end
            end
            pia_pkg::MODE_TRIANGLES: begin
                if (phase3 == 2'd2) begin
                    res0    = pia_pkg::f_face(r_held[1], r_held[0], cur, r_offsets);
                    res_cnt = 2'd1;
                end
            end
            pia_pkg::MODE_TRI_STRIP: begin
                if (lpos >= pia_pkg::t_index'(2)) begin
                    // odd positions swap the last two corners
                    if (lpos[0]) begin
                        res0 = pia_pkg::f_face(r_held[1], cur, r_held[0], r_offsets);
                    end else begin
                        res0 = pia_pkg::f_face(r_held[1], r_held[0], cur, r_offsets);
                    end
                    res_cnt = 2'd1;
                end
            end
            pia_pkg::MODE_FAN: begin
                if (lpos >= pia_pkg::t_index'(2)) begin
                    res0    = pia_pkg::f_face(r_anchor, r_held[0], cur, r_offsets);
                    res_cnt = 2'd1;
                end
            end
            pia_pkg::MODE_QUADS: begin
                if (lpos[1:0] == 2'b11) begin
                    res0    = pia_pkg::f_face(r_held[2], r_held[1], r_held[0], r_offsets);
                    res1    = pia_pkg::f_face(r_held[2], r_held[0], cur, r_offsets);
                    res_cnt = 2'd2;
                end
            end
            default: begin
                res0    = pia_pkg::f_point(cur, r_offsets);
                res_cnt = 2'd1;
            end
        endcase
        res0.run_last = (res_cnt == 2'd1);
        res1.run_last = 1'b1;
    end

    assign push_cnt = in_fire ? res_cnt : 2'd0;
    assign n_count  = r_count - {1'b0, out_fire} + push_cnt;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= pia_pkg::MODE_TRIANGLES;
            r_use_uv2 <= 1'b0;
            r_offsets <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pia_pkg::CFG_PRIMITIVE_MODE: r_mode        <= i_cfg_data[2:0];
                pia_pkg::CFG_USE_SECOND_UV:  r_use_uv2     <= i_cfg_data[0];
                pia_pkg::CFG_VERTEX_OFFSET:  r_offsets.vtx <= i_cfg_data;
                pia_pkg::CFG_NORMAL_OFFSET:  r_offsets.nrm <= i_cfg_data;
                pia_pkg::CFG_TEX_OFFSET:     r_offsets.tex <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // vertex history, fan anchor and list position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held[0]  <= '0;
            r_held[1]  <= '0;
            r_held[2]  <= '0;
            r_anchor   <= '0;
            r_list_pos <= '0;
            r_phase3   <= 2'd0;
        end else if (in_fire) begin
            r_held[0]  <= cur;
            r_held[1]  <= r_held[0];
            r_held[2]  <= r_held[1];
            if (lpos == '0) begin
                r_anchor <= cur;
            end
            r_list_pos <= n_list_pos;
            r_phase3   <= n_phase3;
        end
    end

    // result queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 2'd0;
        end else begin
            unique case (push_cnt)
                2'd1:    r_wr_ptr <= f_ptr_inc(r_wr_ptr);
                2'd2:    r_wr_ptr <= f_ptr_inc(f_ptr_inc(r_wr_ptr));
                default: ;
            endcase
            if (out_fire) begin
                r_rd_ptr <= f_ptr_inc(r_rd_ptr);
            end
            r_count <= n_count;
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_queue[r_wr_ptr] <= res0;
        end
        if (push_cnt == 2'd2) begin
            r_queue[f_ptr_inc(r_wr_ptr)] <= res1;
        end
    end

endmodule

FILE: rtl/pia_checker.sv
module pia_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    input  pia_pkg::t_out_beat                   o_out_beat
);

    // queue comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat shown right after reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_beat))
        else $error("stalled result beat changed or dropped");

    // lines carry no normals and no third corner
    a_line_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.prim_kind == pia_pkg::KIND_LINE |->
            o_out_beat.a_normal == '0 && o_out_beat.b_normal == '0 &&
            o_out_beat.c_position == '0 && o_out_beat.c_texcoord == '0 &&
            o_out_beat.c_normal == '0)
        else $error("line beat with nonzero unused corner fields");

    // point beats repeat one position and carry no a texcoord and no c normal
    a_point_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.prim_kind == pia_pkg::KIND_POINT |->
            o_out_beat.a_position == o_out_beat.b_position &&
            o_out_beat.b_position == o_out_beat.c_position &&
            o_out_beat.a_texcoord == '0 && o_out_beat.c_normal == '0)
        else $error("malformed point beat");

    // only the three result kinds appear
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_beat.prim_kind != 2'd3)
        else $error("unknown primitive kind");

endmodule

bind primitive_index_assembler pia_checker u_pia_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_beat  (o_out_beat)
);
